>>> src/bnte_pkg.sv
// ----------------------------------------------------------------------------
// bnte_pkg
// Shared constants, types and alphabet functions of the Base16/32/64 encoder.
// ----------------------------------------------------------------------------
package bnte_pkg;

  // Symbol counter width; any value from 8 to 32 works.
  localparam int CountWidth = 16;
  localparam int CapWidth   = 16;
  localparam int CmpWidth   = (CountWidth > CapWidth) ? CountWidth : CapWidth;

  // Results one input beat may place on the output.
  localparam logic [3:0] MaxResults = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] CfgAlphabetMode = 2'd0;
  localparam logic [1:0] CfgCapacity     = 2'd1;

  // Alphabet modes.
  localparam logic [1:0] ModeBase16 = 2'd0;
  localparam logic [1:0] ModeBase32 = 2'd1;
  localparam logic [1:0] ModeBase64 = 2'd2;

  localparam logic [7:0] PadChar = 8'd61;  // '='

  // Result of the shared group extract unit.
  typedef struct packed {
    logic       ge;      // enough accumulated bits for one group
    logic [3:0] rem;     // bit count left after taking the group
    logic [7:0] symbol;  // ASCII symbol of that group
  } sym_res_t;

  function automatic logic [2:0] group_bits(logic [1:0] mode);
    logic [2:0] bits;
    unique case (mode)
      ModeBase16: bits = 3'd4;
      ModeBase32: bits = 3'd5;
      default:    bits = 3'd6;  // Base64, unused code too
    endcase
    return bits;
  endfunction

  function automatic logic [7:0] alpha_sym(logic [2:0] bits, logic [5:0] idx);
    logic [7:0] i8;
    logic [7:0] sym;
    i8 = {2'b00, idx};
    priority if (bits == 3'd4) begin
      if (i8 < 8'd10) sym = 8'd48 + i8;        // '0'..'9'
      else            sym = 8'd55 + i8;        // 'A'..'F'
    end else if (bits == 3'd5) begin
      if (i8 < 8'd26) sym = 8'd65 + i8;        // 'A'..'Z'
      else            sym = 8'd24 + i8;        // '2'..'7'
    end else begin
      if      (i8 < 8'd26) sym = 8'd65 + i8;   // 'A'..'Z'
      else if (i8 < 8'd52) sym = 8'd71 + i8;   // 'a'..'z'
      else if (i8 < 8'd62) sym = i8 - 8'd4;    // '0'..'9'
      else if (i8 == 8'd62) sym = 8'd43;       // '+'
      else                 sym = 8'd47;        // '/'
    end
    return sym;
  endfunction

endpackage

>>> src/base_n_text_encoder.sv
// ----------------------------------------------------------------------------
// base_n_text_encoder
// Byte stream to Base16/Base32/Base64 text, with '=' padding and capacity cut.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in_valid_i/in_ready_o   | data_byte_i, final_byte_i
//  out     | out_valid_o/out_ready_i | symbol_o, has_symbol_o,
//          |                         | end_of_string_o, overflow_o
//
//  Sequence: accept, then the shared group unit takes one 4/5/6-bit group at
//  a time until too few bits are left, then the beat closes. A final beat
//  with leftover bits goes on to the last partial symbol, each '=' or carry
//  step, a check that the group is closed, and the end beat; with no
//  leftover only the end beat.
//  Reset: mode Base64, capacity 65535, leftover bits and counter empty.
//  Stalls: the sequencer freezes when a symbol finds the output register
//  (and, on a final beat, the one-symbol hold) occupied, and the end beat
//  waits for a free output register.
//  Config writes are always taken (cfg_ready_o is tied high).
//
module base_n_text_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  // output symbols
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  symbol_o,
  output logic        has_symbol_o,
  output logic        end_of_string_o,
  output logic        overflow_o
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StMain   = 5'b00010,  // take full groups of the current beat
    StFinSym = 5'b00100,  // zero-padded last symbol
    StPad    = 5'b01000,  // '=' padding
    StEnd    = 5'b10000   // end-of-string beat
  } state_e;

  localparam int CW = bnte_pkg::CountWidth;

  state_e state_q, state_d;

  // Config registers
  logic [1:0]  mode_q;
  logic [15:0] cap_q;

  // String state across beats
  logic [3:0]    lb_q, lb_d;      // leftover bits
  logic [2:0]    lc_q, lc_d;      // leftover count
  logic [CW-1:0] emit_q, emit_d;  // symbols stored

  // Per-beat working registers
  logic [13:0] acc_q, acc_d;
  logic [3:0]  b_q, b_d;
  logic        fin_q, fin_d;
  logic [3:0]  n_q, n_d;
  logic [3:0]  guard_q, guard_d;

  // One-deep hold: on a final beat the last symbol must carry end/overflow.
  logic       hold_v_q, hold_v_d;
  logic [7:0] hold_sym_q, hold_sym_d;

  // Output register
  logic       out_v_q, out_v_d;
  logic [7:0] out_sym_q, out_sym_d;
  logic       out_has_q, out_has_d;
  logic       out_eos_q, out_eos_d;
  logic       out_ovf_q, out_ovf_d;

  bnte_pkg::sym_res_t su;

  logic [bnte_pkg::CmpWidth-1:0] lim;
  logic [bnte_pkg::CmpWidth-1:0] cap_ext;
  logic [bnte_pkg::CmpWidth-1:0] count_max;
  logic        room;
  logic        out_free;
  logic        want_emit, want_put, put_ok, put_go, stall;
  logic [7:0]  put_sym;
  logic [13:0] acc_masked;

  bnte_sym_unit u_sym (
    .acc_i  (acc_q),
    .bcnt_i (b_q),
    .mode_i (mode_q),
    .res_o  (su)
  );

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == StIdle);
  assign out_valid_o     = out_v_q;
  assign symbol_o        = out_sym_q;
  assign has_symbol_o    = out_has_q;
  assign end_of_string_o = out_eos_q;
  assign overflow_o      = out_ovf_q;

  // Store limit: min(capacity, counter max)
  assign count_max = bnte_pkg::CmpWidth'({CW{1'b1}});
  assign cap_ext   = bnte_pkg::CmpWidth'(cap_q);
  assign lim       = (cap_ext < count_max) ? cap_ext : count_max;
  assign room      = (bnte_pkg::CmpWidth'(emit_q) < lim);
  assign out_free  = !out_v_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    lb_d       = lb_q;
    lc_d       = lc_q;
    emit_d     = emit_q;
    acc_d      = acc_q;
    b_d        = b_q;
    fin_d      = fin_q;
    n_d        = n_q;
    guard_d    = guard_q;
    hold_v_d   = hold_v_q;
    hold_sym_d = hold_sym_q;
    out_v_d    = out_v_q && !out_ready_i;
    out_sym_d  = out_sym_q;
    out_has_d  = out_has_q;
    out_eos_d  = out_eos_q;
    out_ovf_d  = out_ovf_q;
    want_emit  = 1'b0;
    put_sym    = su.symbol;
    acc_masked = acc_q & ((14'd1 << b_q) - 14'd1);

    // symbols past the limit, or past the per-beat maximum, are dropped
    put_ok   = fin_q ? (!hold_v_q || out_free) : out_free;
    want_put = 1'b0;
    stall    = 1'b0;
    put_go   = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          acc_d   = {2'b00, lb_q, data_byte_i};
          b_d     = {1'b0, lc_q} + 4'd8;
          fin_d   = final_byte_i;
          n_d     = '0;
          state_d = StMain;
        end
      end
      StMain: begin
        if (su.ge) begin
          want_emit = 1'b1;
        end else if (!fin_q) begin
          lb_d    = acc_masked[3:0];
          lc_d    = b_q[2:0];
          state_d = StIdle;
        end else if (b_q != 4'd0) begin
          acc_d   = {acc_masked[5:0], 8'h00};
          b_d     = b_q + 4'd8;
          state_d = StFinSym;
        end else begin
          state_d = StEnd;
        end
      end
      StFinSym: begin
        want_emit = 1'b1;
      end
      StPad: begin
        put_sym = bnte_pkg::PadChar;
        if (su.ge) begin
          want_emit = 1'b1;
        end else if (b_q == 4'd0) begin
          state_d = StEnd;
        end else begin
          b_d     = b_q + 4'd8;
          guard_d = guard_q + 4'd1;
          if (guard_q == 4'd15) state_d = StEnd;  // padding never lines up
        end
      end
      StEnd: begin
        if (out_free) begin
          out_v_d   = 1'b1;
          out_eos_d = 1'b1;
          out_ovf_d = !room;
          if (hold_v_q) begin
            out_sym_d = hold_sym_q;
            out_has_d = 1'b1;
          end else begin
            out_sym_d = 8'h00;   // status-only end beat
            out_has_d = 1'b0;
          end
          hold_v_d = 1'b0;
          lb_d     = '0;
          lc_d     = '0;
          emit_d   = '0;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // Group step: advance unless a stored symbol has nowhere to go
    want_put = want_emit && room && (n_q < bnte_pkg::MaxResults);
    stall    = want_put && !put_ok;
    put_go   = want_put && put_ok;
    if (want_emit && !stall) begin
      b_d = su.rem;
      if (state_q == StFinSym) begin
        guard_d = '0;
        state_d = StPad;
      end
    end

    if (put_go) begin
      n_d    = n_q + 4'd1;
      emit_d = emit_q + CW'(1);
      if (fin_q) begin
        if (hold_v_q) begin
          out_v_d   = 1'b1;
          out_sym_d = hold_sym_q;
          out_has_d = 1'b1;
          out_eos_d = 1'b0;
          out_ovf_d = 1'b0;
        end
        hold_v_d   = 1'b1;
        hold_sym_d = put_sym;
      end else begin
        out_v_d   = 1'b1;
        out_sym_d = put_sym;
        out_has_d = 1'b1;
        out_eos_d = 1'b0;
        out_ovf_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      lb_q     <= '0;
      lc_q     <= '0;
      emit_q   <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      lb_q     <= lb_d;
      lc_q     <= lc_d;
      emit_q   <= emit_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bnte_pkg::ModeBase64;
      cap_q  <= 16'hffff;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == bnte_pkg::CfgAlphabetMode) mode_q <= cfg_data_i[1:0];
      if (cfg_index_i == bnte_pkg::CfgCapacity)     cap_q  <= cfg_data_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    b_q        <= b_d;
    fin_q      <= fin_d;
    n_q        <= n_d;
    guard_q    <= guard_d;
    hold_sym_q <= hold_sym_d;
    out_sym_q  <= out_sym_d;
    out_has_q  <= out_has_d;
    out_eos_q  <= out_eos_d;
    out_ovf_q  <= out_ovf_d;
  end

endmodule

>>> src/bnte_sym_unit.sv
// ----------------------------------------------------------------------------
// bnte_sym_unit
// Shared group unit: compare, subtract, shift out one group, map to ASCII.
// ----------------------------------------------------------------------------
module bnte_sym_unit (
  input  logic [13:0]        acc_i,
  input  logic [3:0]         bcnt_i,
  input  logic [1:0]         mode_i,
  output bnte_pkg::sym_res_t res_o
);

  logic [2:0]  bits;
  logic [3:0]  rem;
  logic [13:0] shifted;
  logic [5:0]  mask;

  always_comb begin
    bits    = bnte_pkg::group_bits(mode_i);
    rem     = bcnt_i - {1'b0, bits};
    shifted = acc_i >> rem;
    unique case (bits)
      3'd4:    mask = 6'h0f;
      3'd5:    mask = 6'h1f;
      default: mask = 6'h3f;
    endcase
    res_o.ge     = (bcnt_i >= {1'b0, bits});
    res_o.rem    = rem;
    res_o.symbol = bnte_pkg::alpha_sym(bits, shifted[5:0] & mask);
  end

endmodule

>>> src/bnte_checker.sv
// ----------------------------------------------------------------------------
// bnte_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module bnte_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] symbol_o,
  input logic       has_symbol_o,
  input logic       end_of_string_o,
  input logic       overflow_o
);

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(symbol_o)
      && $stable(has_symbol_o) && $stable(end_of_string_o) && $stable(overflow_o))
    else $error("output beat changed while stalled");

  // Status-only beats appear only at end of string
  a_status_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_symbol_o |-> end_of_string_o)
    else $error("status-only beat without end of string");

  // Overflow is reported only on the end beat
  a_ovf_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> end_of_string_o)
    else $error("overflow outside end beat");

  // One byte at a time: input closes after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input reopened right after an accept");

endmodule

bind base_n_text_encoder bnte_checker u_bnte_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .symbol_o        (symbol_o),
  .has_symbol_o    (has_symbol_o),
  .end_of_string_o (end_of_string_o),
  .overflow_o      (overflow_o)
);

>>> tb/bnte_checker.sv
// ----------------------------------------------------------------------------
// bnte_scoreboard
// Watches the config, byte and symbol channels of the encoder, predicts the
// symbol beats of each accepted byte and compares them in order.
// ----------------------------------------------------------------------------
module bnte_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  symbol_i,
  input  logic        has_symbol_i,
  input  logic        end_of_string_i,
  input  logic        overflow_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] symbol;
    logic       has_symbol;
    logic       end_of_string;
    logic       overflow;
  } sym_beat_t;

  string b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  string b32_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
  string hex_chars = "0123456789ABCDEF";

  // Shadow of the encoder state
  logic [1:0]                      mode_q;
  logic [15:0]                     cap_q;
  logic [3:0]                      left_bits;
  int                              left_cnt;
  logic [bnte_pkg::CountWidth-1:0] sym_count;

  sym_beat_t step_beats[$];   // beats of the byte being predicted
  sym_beat_t expected_q[$];   // beats still owed by the encoder
  int        n_errors = 0;

  assign errors_o = n_errors;

  function automatic logic [7:0] alphabet_char(int width, int idx);
    if (width == 4) return hex_chars[idx & 15];
    if (width == 5) return b32_chars[idx & 31];
    return b64_chars[idx & 63];
  endfunction

  // Stored only below capacity, the counter maximum and 8 beats per byte; dropped otherwise.
  task automatic store_symbol(logic [7:0] sym);
    sym_beat_t beat;
    if (sym_count < cap_q && sym_count != '1 && step_beats.size() < 8) begin
      beat.symbol        = sym;
      beat.has_symbol    = 1'b1;
      beat.end_of_string = 1'b0;
      beat.overflow      = 1'b0;
      step_beats.push_back(beat);
      sym_count++;
    end
  endtask

  task automatic encode_byte(logic [7:0] data, logic last);
    int        width;
    int        mask;
    int        acc;
    int        avail;
    int        guard;
    sym_beat_t tail;
    step_beats.delete();
    width = (mode_q == bnte_pkg::ModeBase16) ? 4 :
            (mode_q == bnte_pkg::ModeBase32) ? 5 : 6;
    mask  = (1 << width) - 1;
    acc   = {left_bits, data};
    avail = left_cnt + 8;
    while (avail >= width) begin
      avail -= width;
      store_symbol(alphabet_char(width, (acc >> avail) & mask));
    end
    acc &= (1 << avail) - 1;
    if (!last) begin
      left_bits = acc[3:0];
      left_cnt  = avail;
    end else begin
      if (avail != 0) begin
        // zero-padded last symbol, then '=' until the group closes
        acc   = acc << 8;
        avail = avail + 8 - width;
        store_symbol(alphabet_char(width, (acc >> avail) & mask));
        guard = 0;
        while (avail != 0 && guard < 16) begin
          while (avail >= width) begin
            avail -= width;
            store_symbol(bnte_pkg::PadChar);
          end
          if (avail != 0) avail += 8;
          guard++;
        end
      end
      if (step_beats.size() == 0) begin
        tail = '0;  // status-only end beat
      end else begin
        tail = step_beats.pop_back();
      end
      tail.end_of_string = 1'b1;
      tail.overflow      = (sym_count >= cap_q) || (sym_count == '1);
      step_beats.push_back(tail);
      left_bits = '0;
      left_cnt  = 0;
      sym_count = '0;
    end
    foreach (step_beats[i]) expected_q.push_back(step_beats[i]);
  endtask

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("[%0t] %s mismatch: expected 'h%0h, got 'h%0h", $time, what, want, got);
    n_errors++;
  endtask

  task automatic check_beat();
    sym_beat_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected beat, symbol", 8'h00, symbol_i);
    end else begin
      want = expected_q.pop_front();
      if (symbol_i !== want.symbol) report_mismatch("symbol", want.symbol, symbol_i);
      if (has_symbol_i !== want.has_symbol) begin
        report_mismatch("has_symbol", 8'(want.has_symbol), 8'(has_symbol_i));
      end
      if (end_of_string_i !== want.end_of_string) begin
        report_mismatch("end_of_string", 8'(want.end_of_string), 8'(end_of_string_i));
      end
      if (overflow_i !== want.overflow) begin
        report_mismatch("overflow", 8'(want.overflow), 8'(overflow_i));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    = bnte_pkg::ModeBase64;
      cap_q     = 16'hFFFF;
      left_bits = '0;
      left_cnt  = 0;
      sym_count = '0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_beat();
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == bnte_pkg::CfgAlphabetMode) mode_q = cfg_data_i[1:0];
        else if (cfg_index_i == bnte_pkg::CfgCapacity) cap_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) encode_byte(data_byte_i, final_byte_i);
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte strings into the Base16/32/64 encoder under changing alphabet
// and capacity settings, with random gaps and output stalls; the scoreboard
// beside the encoder predicts and compares every symbol beat.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Random part stops after about this many bytes.
  localparam int RandomBytes  = 430;
  // Quiet cycles after the last owed beat; covers a final beat that is still
  // closing or a byte whose symbols were all dropped.
  localparam int SettleCycles = 24;
  // Worst case per byte: the longest input gap, the encoder's own steps, and
  // 8 beats each behind the longest output stall; ~500 bytes plus phase
  // settles stay well below a quarter of this limit.
  localparam int CycleLimit   = 400000;

  logic        clk;
  logic        rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = bnte_pkg::CfgAlphabetMode;
  logic [15:0] cfg_data  = '0;

  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte  = '0;
  logic        final_byte = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  symbol;
  logic        has_symbol;
  logic        end_of_string;
  logic        overflow;

  int          errors;
  int          pending;
  int          bytes_sent  = 0;
  int          cycle_count = 0;

  // When set, that side runs with no idle cycles at all
  bit          calm_in  = 1'b0;
  bit          calm_out = 1'b0;

  base_n_text_encoder u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (data_byte),
    .final_byte_i    (final_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .symbol_o        (symbol),
    .has_symbol_o    (has_symbol),
    .end_of_string_o (end_of_string),
    .overflow_o      (overflow)
  );

  bnte_scoreboard u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .data_byte_i     (data_byte),
    .final_byte_i    (final_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .symbol_i        (symbol),
    .has_symbol_i    (has_symbol),
    .end_of_string_i (end_of_string),
    .overflow_i      (overflow),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog: a hung handshake or a lost beat ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // Mostly random bytes, with all-zero and all-one bytes mixed in.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: random stall before every beat, none when calm_out is set.
  initial begin : symbol_sink
    int stall;
    wait (rst_n);
    forever begin
      stall = pick_wait(calm_out);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // One byte beat. Valid stays up across back-to-back beats; it only drops
  // when a gap is drawn, so it never sees two assignments in one step.
  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = pick_wait(calm_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= value;
    final_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_string(input int len);
    for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
  endtask

  // Sender holds off until every owed beat is out and the encoder has gone
  // quiet. The first wait lets the scoreboard see the last accepted byte.
  task automatic drain_encoder();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_alphabet(input logic [1:0] mode, input logic [15:0] cap);
    drain_encoder();
    write_reg(bnte_pkg::CfgAlphabetMode, {14'd0, mode});
    write_reg(bnte_pkg::CfgCapacity, cap);
  endtask

  initial begin : stimulus
    logic [1:0]  mode;
    logic [15:0] cap;
    int          start_count;
    wait (rst_n);
    @(posedge clk);

    // ---- directed ----
    // Reset setting: Base64, full capacity. "Man" is a whole group,
    // then one and two byte tails that need '=' padding.
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Base32: single byte gives the longest padding run
    set_alphabet(bnte_pkg::ModeBase32, 16'hFFFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);

    // Base16: never any leftover or padding
    set_alphabet(bnte_pkg::ModeBase16, 16'hFFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b1);

    // unused mode code behaves as Base64
    set_alphabet(2'd3, 16'hFFFF);
    send_byte(8'h5A, 1'b1);

    // zero capacity: all dropped, lone status beat flagging overflow
    set_alphabet(bnte_pkg::ModeBase64, 16'h0000);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);

    // capacity cut in the middle of the string
    set_alphabet(bnte_pkg::ModeBase64, 16'd3);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hCD, 1'b0);
    send_byte(8'hEF, 1'b1);

    // mode switch mid-string: leftover bits carry into the new width
    set_alphabet(bnte_pkg::ModeBase64, 16'hFFFF);
    send_byte(8'h3C, 1'b0);
    set_alphabet(bnte_pkg::ModeBase16, 16'hFFFF);
    send_byte(8'hC3, 1'b1);
    set_alphabet(bnte_pkg::ModeBase64, 16'hFFFF);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    set_alphabet(bnte_pkg::ModeBase32, 16'hFFFF);
    send_byte(8'h81, 1'b1);

    // smallest nonzero capacity
    set_alphabet(bnte_pkg::ModeBase16, 16'd1);
    send_byte(8'h7E, 1'b1);

    // ---- random phases ----
    start_count = bytes_sent;
    while (bytes_sent - start_count < RandomBytes) begin
      mode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0:       cap = 16'hFFFF;
        1:       cap = 16'd1;
        2:       cap = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'hFFFF;
        3:       cap = 16'($urandom_range(1, 65535));
        default: cap = 16'($urandom_range(2, 30));
      endcase
      // Sometimes only one register changes, leaving the other as it was.
      drain_encoder();
      case ($urandom_range(0, 3))
        0:       write_reg(bnte_pkg::CfgAlphabetMode, {14'd0, mode});
        1:       write_reg(bnte_pkg::CfgCapacity, cap);
        default: begin
          write_reg(bnte_pkg::CfgAlphabetMode, {14'd0, mode});
          write_reg(bnte_pkg::CfgCapacity, cap);
        end
      endcase
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 7) == 0) send_string($urandom_range(13, 30));
        else send_string($urandom_range(1, 12));
      end
      // leave a string open so the next setting picks it up mid-way
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(pick_byte(), 1'b0);
      end
    end

    calm_in  = 1'b0;
    calm_out = 1'b0;
    drain_encoder();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bnte_pkg.sv
src/bnte_sym_unit.sv
src/base_n_text_encoder.sv
src/bnte_checker.sv
tb/bnte_checker.sv
tb/testbench.sv
